/* rtl/core/cftc_pkg.sv */
// ----------------------------------------------------------------------------
// cftc_pkg: shared types and constants of the chained frame transfer control
// Action codes, phases, front-end operation codes and the command word that
// travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package cftc_pkg;

   localparam int LEN_BITS  = 16;   // width of lengths and buffer offsets
   localparam int CNT_BITS  = 8;    // width of a header length or frame size
   localparam int MAX_FRAME = 254;  // largest transmit frame in bytes
   localparam int CHAIN_BIT = 7;    // chain flag position in the first header byte
   localparam int QDEPTH    = 2;    // words held between front and back end
   localparam int QPTR_BITS = $clog2(QDEPTH);
   localparam int QCNT_BITS = $clog2(QDEPTH + 1);

   typedef logic [LEN_BITS-1:0] len_type;
   typedef logic [CNT_BITS-1:0] cnt_type;

   // Input word kinds
   localparam logic [1:0] KIND_START   = 2'd0;
   localparam logic [1:0] KIND_HEADER  = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD = 2'd2;

   typedef enum logic [2:0] {
      ACT_SEND    = 3'd0,
      ACT_WAIT    = 3'd1,
      ACT_PAYLOAD = 3'd2,
      ACT_HEADER  = 3'd3,
      ACT_DONE    = 3'd4,
      ACT_COMM    = 3'd5,
      ACT_OVER    = 3'd6,
      ACT_UNEXP   = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      OP_START    = 3'd0,
      OP_HDR_WAIT = 3'd1,
      OP_HDR_NEXT = 3'd2,
      OP_HDR_DATA = 3'd3,
      OP_PAY_DONE = 3'd4,
      OP_OTHER    = 3'd5
   } op_type;

   typedef struct packed {
      op_type  op;
      logic    chain;
      cnt_type hlen;
      len_type tx_length;
      len_type rx_capacity;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic valid;
   } qstat_type;

endpackage

`default_nettype wire

/* rtl/core/cftc_front.sv */
// ----------------------------------------------------------------------------
// cftc_front: input word classifier
// Turns the kind and header bytes of an input word into one operation code.
// ----------------------------------------------------------------------------
`default_nettype none

module cftc_front (
   input  wire logic [1:0]              kind,
   input  wire cftc_pkg::len_type       tx_length,
   input  wire cftc_pkg::len_type       rx_capacity,
   input  wire logic [7:0]              header_first,
   input  wire logic [7:0]              header_second,
   output cftc_pkg::cmd_type            cmd
);

   logic chain;

   assign chain = header_first[cftc_pkg::CHAIN_BIT];

   always_comb begin
      cmd             = '0;
      cmd.chain       = chain;
      cmd.hlen        = header_second;
      cmd.tx_length   = tx_length;
      cmd.rx_capacity = rx_capacity;
      unique case (kind)
         cftc_pkg::KIND_START: begin
            cmd.op = cftc_pkg::OP_START;
         end
         cftc_pkg::KIND_HEADER: begin
            if (header_second != '0) begin
               cmd.op = cftc_pkg::OP_HDR_DATA;
            end else if (chain) begin
               cmd.op = cftc_pkg::OP_HDR_NEXT;
            end else begin
               cmd.op = cftc_pkg::OP_HDR_WAIT;
            end
         end
         cftc_pkg::KIND_PAYLOAD: begin
            cmd.op = cftc_pkg::OP_PAY_DONE;
         end
         default: begin
            cmd.op = cftc_pkg::OP_OTHER;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/cftc_queue.sv */
// ----------------------------------------------------------------------------
// cftc_queue: command queue
// Short first-in first-out store of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module cftc_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire cftc_pkg::cmd_type     push_cmd,
   input  wire logic                  pop,
   output cftc_pkg::cmd_type          head_cmd,
   output cftc_pkg::qstat_type        stat
);

   cftc_pkg::cmd_type                   slot_ff [cftc_pkg::QDEPTH];
   logic [cftc_pkg::QPTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [cftc_pkg::QPTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [cftc_pkg::QCNT_BITS-1:0]      count_ff, count_in;
   logic                                do_push, do_pop;

   assign stat.full  = (count_ff == cftc_pkg::QCNT_BITS'(cftc_pkg::QDEPTH));
   assign stat.valid = (count_ff != '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && stat.valid;
   assign head_cmd   = slot_ff[rd_ptr_ff];

   // advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == cftc_pkg::QPTR_BITS'(cftc_pkg::QDEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == cftc_pkg::QPTR_BITS'(cftc_pkg::QDEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/cftc_back.sv */
// ----------------------------------------------------------------------------
// cftc_back: transfer sequencer
// Carries out one queued command per cycle, while the output is free or
// being read, against the transfer state and registers the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module cftc_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cftc_pkg::qstat_type   qstat,
   input  wire cftc_pkg::cmd_type     cmd,
   output logic                       pop,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output cftc_pkg::action_type       out_action,
   output cftc_pkg::len_type          out_offset,
   output cftc_pkg::cnt_type          out_count,
   output cftc_pkg::len_type          out_total
);

   localparam cftc_pkg::len_type MAX_LEN = cftc_pkg::LEN_BITS'(cftc_pkg::MAX_FRAME);

   cftc_pkg::phase_type   phase_ff, phase_in;
   cftc_pkg::len_type     send_off_ff, send_off_in;
   cftc_pkg::len_type     send_rem_ff, send_rem_in;
   cftc_pkg::len_type     recv_off_ff, recv_off_in;
   cftc_pkg::len_type     recv_lim_ff, recv_lim_in;
   logic                  more_ff, more_in;

   logic                  out_valid_ff, out_valid_in;
   cftc_pkg::action_type  out_action_ff, act;
   cftc_pkg::len_type     out_offset_ff, off;
   cftc_pkg::cnt_type     out_count_ff, cnt;
   cftc_pkg::len_type     out_total_ff;

   logic                  is_start;
   cftc_pkg::len_type     src_rem, src_off, frame_len;
   logic [cftc_pkg::LEN_BITS:0] recv_end;
   logic                  overflow;

   assign pop = qstat.valid && (!out_valid_ff || out_ready);

   // next transmit frame, from the start word or from the running state
   assign is_start  = (cmd.op == cftc_pkg::OP_START);
   assign src_rem   = is_start ? cmd.tx_length : send_rem_ff;
   assign src_off   = is_start ? '0 : send_off_ff;
   assign frame_len = (src_rem > MAX_LEN) ? MAX_LEN : src_rem;

   assign recv_end = {1'b0, recv_off_ff}
                   + {{(cftc_pkg::LEN_BITS + 1 - cftc_pkg::CNT_BITS){1'b0}}, cmd.hlen};
   assign overflow = recv_end > {1'b0, recv_lim_ff};

   always_comb begin
      phase_in    = phase_ff;
      send_off_in = send_off_ff;
      send_rem_in = send_rem_ff;
      recv_off_in = recv_off_ff;
      recv_lim_in = recv_lim_ff;
      more_in     = more_ff;
      act         = cftc_pkg::ACT_UNEXP;
      off         = '0;
      cnt         = '0;
      unique case (cmd.op)
         cftc_pkg::OP_START: begin
            recv_off_in = '0;
            recv_lim_in = cmd.rx_capacity;
            more_in     = 1'b0;
            send_off_in = src_off + frame_len;
            send_rem_in = src_rem - frame_len;
            phase_in    = cftc_pkg::PH_HEADER;
            act         = cftc_pkg::ACT_SEND;
            off         = src_off;
            cnt         = frame_len[cftc_pkg::CNT_BITS-1:0];
         end
         cftc_pkg::OP_HDR_WAIT: begin
            if (phase_ff == cftc_pkg::PH_HEADER) begin
               act = cftc_pkg::ACT_WAIT;
            end
         end
         cftc_pkg::OP_HDR_NEXT: begin
            if (phase_ff == cftc_pkg::PH_HEADER) begin
               if (send_rem_ff != '0) begin
                  send_off_in = src_off + frame_len;
                  send_rem_in = src_rem - frame_len;
                  act         = cftc_pkg::ACT_SEND;
                  off         = src_off;
                  cnt         = frame_len[cftc_pkg::CNT_BITS-1:0];
               end else begin
                  phase_in = cftc_pkg::PH_IDLE;
                  act      = cftc_pkg::ACT_COMM;
               end
            end
         end
         cftc_pkg::OP_HDR_DATA: begin
            if (phase_ff == cftc_pkg::PH_HEADER) begin
               if (overflow) begin
                  phase_in = cftc_pkg::PH_IDLE;
                  act      = cftc_pkg::ACT_OVER;
               end else begin
                  recv_off_in = recv_end[cftc_pkg::LEN_BITS-1:0];
                  more_in     = cmd.chain;
                  phase_in    = cftc_pkg::PH_PAYLOAD;
                  act         = cftc_pkg::ACT_PAYLOAD;
                  off         = recv_off_ff;
                  cnt         = cmd.hlen;
               end
            end
         end
         cftc_pkg::OP_PAY_DONE: begin
            if (phase_ff == cftc_pkg::PH_PAYLOAD) begin
               if (more_ff) begin
                  phase_in = cftc_pkg::PH_HEADER;
                  act      = cftc_pkg::ACT_HEADER;
               end else begin
                  phase_in = cftc_pkg::PH_IDLE;
                  act      = cftc_pkg::ACT_DONE;
               end
            end
         end
         default: begin
            act = cftc_pkg::ACT_UNEXP;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= cftc_pkg::PH_IDLE;
         send_off_ff  <= '0;
         send_rem_ff  <= '0;
         recv_off_ff  <= '0;
         recv_lim_ff  <= '0;
         more_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            phase_ff    <= phase_in;
            send_off_ff <= send_off_in;
            send_rem_ff <= send_rem_in;
            recv_off_ff <= recv_off_in;
            recv_lim_ff <= recv_lim_in;
            more_ff     <= more_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_action_ff <= act;
         out_offset_ff <= off;
         out_count_ff  <= cnt;
         out_total_ff  <= recv_off_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_action = out_action_ff;
   assign out_offset = out_offset_ff;
   assign out_count  = out_count_ff;
   assign out_total  = out_total_ff;

endmodule

`default_nettype wire

/* rtl/core/chained_frame_transfer_control.sv */
// ----------------------------------------------------------------------------
// chained_frame_transfer_control: chained command/response transfer steering
// Decides, word by word, the next bus action of a chained exchange with a
// secure element: transmit frames, header waits, payload reads, completion.
// ----------------------------------------------------------------------------
// Each request word (start, header arrived, payload read finished) yields
// exactly one response word naming the next action, its buffer offset, its
// byte count and the receive bytes accounted so far. A new request word is
// taken every cycle while the queue is not full: the classifier feeds a
// two-word queue, and the sequencer retires one queued word per cycle into
// its output register while that register is free or being read, so a
// response is held in a queue slot, then in the output register. A start
// word aborts any running transfer. Transmit frames are at most 254 bytes.
`default_nettype none

module chained_frame_transfer_control (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tx_length [15:0], rx_capacity [31:16], header_first [39:32],
   // header_second [47:40]
   input  wire logic [47:0] req_tdata,
   // kind [1:0]
   input  wire logic [1:0]  req_tuser,
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // buffer_offset [15:0], byte_count [23:16], total_received [39:24]
   output logic [39:0]      rsp_tdata,
   // action [2:0]
   output logic [2:0]       rsp_tuser
);

   cftc_pkg::cmd_type     front_cmd;
   cftc_pkg::cmd_type     head_cmd;
   cftc_pkg::qstat_type   qstat;
   logic                  pop;
   cftc_pkg::action_type  out_action;
   cftc_pkg::len_type     out_offset;
   cftc_pkg::cnt_type     out_count;
   cftc_pkg::len_type     out_total;

   // hold requests off only when the queue is full
   assign req_tready = !qstat.full;

   // classify the incoming word
   cftc_front u_front (
      .kind          (req_tuser),
      .tx_length     (req_tdata[15:0]),
      .rx_capacity   (req_tdata[31:16]),
      .header_first  (req_tdata[39:32]),
      .header_second (req_tdata[47:40]),
      .cmd           (front_cmd)
   );

   // decouple acceptance from execution
   cftc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_tvalid),
      .push_cmd (front_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .stat     (qstat)
   );

   // execute against the transfer state and register the response
   cftc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .cmd        (head_cmd),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_action (out_action),
      .out_offset (out_offset),
      .out_count  (out_count),
      .out_total  (out_total)
   );

   assign rsp_tdata = {out_total, out_count, out_offset};
   assign rsp_tuser = out_action;

`ifndef NO_ASSERTIONS
   // a transmit frame never exceeds the frame limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == cftc_pkg::ACT_SEND)
      |-> (rsp_tdata[23:16] <= 8'(cftc_pkg::MAX_FRAME)))
      else $error("transmit frame longer than the frame limit");

   // only send and payload actions carry an offset or a count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != cftc_pkg::ACT_SEND)
      && (rsp_tuser != cftc_pkg::ACT_PAYLOAD)
      |-> (rsp_tdata[23:0] == 24'd0))
      else $error("offset or count set on an action without data");

   // after an accepted word, the response register holds a valid word
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 !reset |=> rsp_tvalid)
      else $error("accepted word did not reach the response register");
`endif

endmodule

`default_nettype wire
